// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("property violated");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== hdl/citu_pkg.sv =====
`default_nettype none

package citu_pkg;

  // item kinds carried in tuser
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_FLAG  = 2'd3
  } action_e;

  typedef logic [15:0] count_t;
  typedef logic [7:0]  cycles_t;

  // timer step result
  typedef struct packed {
    count_t count;
    logic   underflow;
  } timer_res_t;

  // register map
  localparam logic [3:0] ADDR_PORT_A  = 4'd0;
  localparam logic [3:0] ADDR_PORT_B  = 4'd1;
  localparam logic [3:0] ADDR_DDR_A   = 4'd2;
  localparam logic [3:0] ADDR_DDR_B   = 4'd3;
  localparam logic [3:0] ADDR_TA_LO   = 4'd4;
  localparam logic [3:0] ADDR_TA_HI   = 4'd5;
  localparam logic [3:0] ADDR_TB_LO   = 4'd6;
  localparam logic [3:0] ADDR_TB_HI   = 4'd7;
  localparam logic [3:0] ADDR_TOD_0   = 4'd8;
  localparam logic [3:0] ADDR_TOD_1   = 4'd9;
  localparam logic [3:0] ADDR_TOD_2   = 4'd10;
  localparam logic [3:0] ADDR_TOD_3   = 4'd11;
  localparam logic [3:0] ADDR_SDR     = 4'd12;
  localparam logic [3:0] ADDR_ICR     = 4'd13;
  localparam logic [3:0] ADDR_CRA     = 4'd14;
  localparam logic [3:0] ADDR_CRB     = 4'd15;

  // register field constants
  localparam logic [7:0] CTRL_STORE_MASK = 8'hEF;
  localparam logic [7:0] ICR_READ_MASK   = 8'h9F;
  localparam logic [1:0] SRC_B_TA_UNDER  = 2'd2;
  localparam count_t     COUNT_RESET     = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hdl/citu_timer.sv =====
`default_nettype none

// one down-count step of a 16-bit timer with reload from its latch
module citu_timer (
  input  citu_pkg::count_t     count_i,
  input  citu_pkg::count_t     latch_i,
  input  citu_pkg::cycles_t    cycles_i,
  output citu_pkg::timer_res_t res_o
);
  import citu_pkg::*;

  count_t cyc_ext;

  assign cyc_ext = {8'd0, cycles_i};

  // underflow when more cycles pass than the count holds; reload minus the excess
  always_comb begin
    res_o.underflow = (cyc_ext > count_i);
    if (res_o.underflow) begin
      res_o.count = latch_i - cyc_ext + count_i;
    end else begin
      res_o.count = count_i - cyc_ext;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cia_timer_interrupt_unit.sv =====
// channel   dir  signals                 contents
// s_axis    in   tdata[31:0], tuser[1:0] word: address, write byte, cycles, port pins; kind
// m_axis    out  tdata[15:0]             word: read byte, irq line
//
// one word per clock sustained while m_axis takes results; a result is offered on m_axis once its word
// has passed from the input register through the single-pass next-state logic
// (timer subtract and reload) into the result register
// reset loads counts and latches with all ones and clears control, flags and mask
// while the result waits, one more word is still taken into the input register
// tready falls only when both registers are full and m_axis is stalled
`default_nettype none

`include "assert_macros.svh"

module cia_timer_interrupt_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: reg_address[3:0], write_value[11:4], elapsed_cycles[19:12],
  //        port_value[27:20], zero fill [31:28]
  input  wire  [31:0] s_axis_tdata,
  // tuser: action[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: read_data[7:0], irq_line[8], zero fill [15:9]
  output logic [15:0] m_axis_tdata
);
  import citu_pkg::*;

  // input register
  logic        in_valid_q, in_valid_d;
  action_e     in_act_q;
  logic [3:0]  in_addr_q;
  logic [7:0]  in_wdata_q;
  cycles_t     in_cyc_q;
  logic [7:0]  in_port_q;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_rdata_q, out_rdata_d;
  logic        out_irq_q, out_irq_d;

  // block state
  logic [7:0]  plain_q [2], plain_d [2];
  logic [7:0]  sdr_q, sdr_d;
  count_t      ta_cnt_q, ta_cnt_d, tb_cnt_q, tb_cnt_d;
  count_t      ta_lat_q, ta_lat_d, tb_lat_q, tb_lat_d;
  logic [7:0]  cra_q, cra_d, crb_q, crb_d;
  logic [7:0]  flags_q, flags_d;
  logic [4:0]  mask_q, mask_d;

  logic        adv;
  logic        in_fire;
  logic        ta_run, tb_run, tb_from_a;
  logic [7:0]  flags_a;
  cycles_t     tb_cyc;
  timer_res_t  ta_res, tb_res;
  count_t      lat_new;
  logic [4:0]  mask_new;
  logic        icr_rd_clr, ta_os_stop;

  // handshake
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_irq_q, out_rdata_q};

  // timer enables and sources
  assign ta_run    = cra_q[0] && !cra_q[5];
  assign flags_a   = flags_q | {7'd0, ta_run && ta_res.underflow};
  assign tb_from_a = (crb_q[6:5] == SRC_B_TA_UNDER);
  assign tb_cyc    = tb_from_a ? 8'd1 : in_cyc_q;
  assign tb_run    = crb_q[0] && (!tb_from_a || flags_a[0]);

  citu_timer u_timer_a (
    .count_i  (ta_cnt_q),
    .latch_i  (ta_lat_q),
    .cycles_i (in_cyc_q),
    .res_o    (ta_res)
  );

  citu_timer u_timer_b (
    .count_i  (tb_cnt_q),
    .latch_i  (tb_lat_q),
    .cycles_i (tb_cyc),
    .res_o    (tb_res)
  );

  // valid flags
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // next state and result for the word in the input register
  always_comb begin
    plain_d     = plain_q;
    sdr_d       = sdr_q;
    ta_cnt_d    = ta_cnt_q;
    tb_cnt_d    = tb_cnt_q;
    ta_lat_d    = ta_lat_q;
    tb_lat_d    = tb_lat_q;
    cra_d       = cra_q;
    crb_d       = crb_q;
    flags_d     = flags_q;
    mask_d      = mask_q;
    out_rdata_d = out_rdata_q;
    lat_new     = ta_lat_q;
    mask_new    = mask_q;
    if (adv) begin
      out_rdata_d = 8'd0;
      unique case (in_act_q)
        ACT_WRITE: begin
          unique case (in_addr_q)
            ADDR_TA_LO: ta_lat_d = {ta_lat_q[15:8], in_wdata_q};
            ADDR_TA_HI: begin
              lat_new  = {in_wdata_q, ta_lat_q[7:0]};
              ta_lat_d = lat_new;
              if (!cra_q[0]) begin
                ta_cnt_d = lat_new;
              end
            end
            ADDR_TB_LO: tb_lat_d = {tb_lat_q[15:8], in_wdata_q};
            ADDR_TB_HI: begin
              lat_new  = {in_wdata_q, tb_lat_q[7:0]};
              tb_lat_d = lat_new;
              if (!crb_q[0]) begin
                tb_cnt_d = lat_new;
              end
            end
            ADDR_TOD_0, ADDR_TOD_1, ADDR_TOD_2, ADDR_TOD_3: ;
            ADDR_SDR: begin
              sdr_d      = in_wdata_q;
              flags_d[3] = 1'b1;
              flags_d[7] = flags_q[7] | mask_q[3];
            end
            ADDR_ICR: begin
              if (in_wdata_q[7]) begin
                mask_new = mask_q | in_wdata_q[4:0];
                if ((flags_q[4:0] & mask_new) != 5'd0) begin
                  flags_d[7] = 1'b1;
                end
              end else begin
                mask_new = mask_q & ~in_wdata_q[4:0];
              end
              mask_d = mask_new;
            end
            ADDR_CRA: begin
              cra_d = in_wdata_q & CTRL_STORE_MASK;
              if (in_wdata_q[4]) begin
                ta_cnt_d = ta_lat_q;
              end
            end
            ADDR_CRB: begin
              crb_d = in_wdata_q & CTRL_STORE_MASK;
              if (in_wdata_q[4]) begin
                tb_cnt_d = tb_lat_q;
              end
            end
            // plain registers for the two direction addresses; both are read back
            ADDR_DDR_A, ADDR_DDR_B: plain_d[in_addr_q[0]] = in_wdata_q;
            default: ;
          endcase
        end
        ACT_READ: begin
          unique case (in_addr_q)
            ADDR_PORT_A, ADDR_PORT_B: out_rdata_d = in_port_q;
            ADDR_DDR_A, ADDR_DDR_B:   out_rdata_d = plain_q[in_addr_q[0]];
            ADDR_TA_LO: out_rdata_d = ta_cnt_q[7:0];
            ADDR_TA_HI: out_rdata_d = ta_cnt_q[15:8];
            ADDR_TB_LO: out_rdata_d = tb_cnt_q[7:0];
            ADDR_TB_HI: out_rdata_d = tb_cnt_q[15:8];
            ADDR_SDR:   out_rdata_d = sdr_q;
            ADDR_ICR: begin
              out_rdata_d = flags_q & ICR_READ_MASK;
              flags_d     = 8'd0;
            end
            ADDR_CRA:   out_rdata_d = cra_q;
            ADDR_CRB:   out_rdata_d = crb_q;
            default:    out_rdata_d = 8'd0;
          endcase
        end
        ACT_TICK: begin
          flags_d = flags_a;
          if (ta_run) begin
            ta_cnt_d = ta_res.count;
            if (ta_res.underflow && cra_q[3]) begin
              cra_d[0] = 1'b0;
            end
          end
          if (tb_run) begin
            tb_cnt_d = tb_res.count;
            if (tb_res.underflow) begin
              flags_d[1] = 1'b1;
              if (crb_q[3]) begin
                crb_d[0] = 1'b0;
              end
            end
          end
          if ((flags_d[3:0] & mask_q[3:0]) != 4'd0) begin
            flags_d[7] = 1'b1;
          end
        end
        ACT_FLAG: begin
          flags_d[4] = 1'b1;
          flags_d[7] = flags_q[7] | mask_q[4];
        end
        default: ;
      endcase
    end
    out_irq_d = adv ? flags_d[7] : out_irq_q;
  end

  // control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      plain_q[0]  <= 8'd0;
      plain_q[1]  <= 8'd0;
      sdr_q       <= 8'd0;
      ta_cnt_q    <= COUNT_RESET;
      tb_cnt_q    <= COUNT_RESET;
      ta_lat_q    <= COUNT_RESET;
      tb_lat_q    <= COUNT_RESET;
      cra_q       <= 8'd0;
      crb_q       <= 8'd0;
      flags_q     <= 8'd0;
      mask_q      <= 5'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      plain_q     <= plain_d;
      sdr_q       <= sdr_d;
      ta_cnt_q    <= ta_cnt_d;
      tb_cnt_q    <= tb_cnt_d;
      ta_lat_q    <= ta_lat_d;
      tb_lat_q    <= tb_lat_d;
      cra_q       <= cra_d;
      crb_q       <= crb_d;
      flags_q     <= flags_d;
      mask_q      <= mask_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_act_q   <= action_e'(s_axis_tuser);
      in_addr_q  <= s_axis_tdata[3:0];
      in_wdata_q <= s_axis_tdata[11:4];
      in_cyc_q   <= s_axis_tdata[19:12];
      in_port_q  <= s_axis_tdata[27:20];
    end
    out_rdata_q <= out_rdata_d;
    out_irq_q   <= out_irq_d;
  end

  // conditions watched by the checks
  assign icr_rd_clr = adv && (in_act_q == ACT_READ) && (in_addr_q == ADDR_ICR);
  assign ta_os_stop = adv && (in_act_q == ACT_TICK) && ta_run && ta_res.underflow && cra_q[3];

  // checks
  `ASSERT_NEVER(a_ctrl_bit4, clk_i, rst_ni, cra_q[4] || crb_q[4])
  `ASSERT_PROP(a_icr_read_clears, clk_i, rst_ni, icr_rd_clr |=> (flags_q == 8'd0))
  `ASSERT_PROP(a_irq_tracks_flags, clk_i, rst_ni, adv |=> (out_irq_q == flags_q[7]))
  `ASSERT_PROP(a_one_shot_stop, clk_i, rst_ni, ta_os_stop |=> !cra_q[0])

endmodule

`default_nettype wire
